// File: rtl/mbiq_pkg.sv
// Shared types and constants for the multichannel biquad filter.
package mbiq_pkg;

  // Channel count and derived widths
  localparam int NUM_CHANNELS = 2;
  localparam int CH_W         = 3;
  localparam int ADDR_W       = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

  // Sample, coefficient and history widths
  localparam int SAMPLE_W = 24;
  localparam int COEF_W   = 32;
  localparam int HIST_Y_W = 40;
  localparam int FRAC_W   = 16;
  localparam int SUM_W    = 76;
  localparam int QSHIFT   = 30;
  localparam int Q_W      = SUM_W - QSHIFT;

  // Register map indexes (word address)
  localparam logic [2:0] REG_FF0 = 3'd0;
  localparam logic [2:0] REG_FF1 = 3'd1;
  localparam logic [2:0] REG_FF2 = 3'd2;
  localparam logic [2:0] REG_FB1 = 3'd3;
  localparam logic [2:0] REG_FB2 = 3'd4;

  // Coefficient reset values (Q2.30 lowpass)
  localparam logic signed [COEF_W-1:0] FF0_RST = 32'sd4204773;
  localparam logic signed [COEF_W-1:0] FF1_RST = 32'sd8409546;
  localparam logic signed [COEF_W-1:0] FF2_RST = 32'sd8409546;
  localparam logic signed [COEF_W-1:0] FB1_RST = -32'sd1949207556;
  localparam logic signed [COEF_W-1:0] FB2_RST = 32'sd892285898;

  // Frame tags on the result
  localparam logic [1:0] TAG_FIRST = 2'd1;
  localparam logic [1:0] TAG_OTHER = 2'd2;

  // Saturation limits of the Q24.16 history
  localparam logic signed [HIST_Y_W-1:0] Y_MAX = {1'b0, {(HIST_Y_W-1){1'b1}}};
  localparam logic signed [HIST_Y_W-1:0] Y_MIN = {1'b1, {(HIST_Y_W-1){1'b0}}};

  // One channel's delay line, one RAM word
  typedef struct packed {
    logic signed [HIST_Y_W-1:0] y2;
    logic signed [HIST_Y_W-1:0] y1;
    logic signed [SAMPLE_W-1:0] x2;
    logic signed [SAMPLE_W-1:0] x1;
  } hist_t;

  localparam int HIST_W = $bits(hist_t);

endpackage

// File: rtl/multichannel_biquad_iir.sv
// Multichannel direct form I biquad with per-channel history kept in RAM.
//
//   channel | handshake               | payload
//   --------+-------------------------+----------------------------------------------
//   input   | s_tvalid, s_tready      | s_tdata: sample_in
//   result  | m_tvalid, m_tready      | m_tdata: sample_out; m_tuser: channel, tag
//   config  | psel, penable, pwrite   | paddr, pwdata: coef_ff0 .. coef_fb2
//
// A result goes through three register stages: stage 1, stage 2 and the output register.
// With two or more channels one sample is taken every cycle while the output does not stall;
// a single channel waits for its own write-back before its next sample is taken.
// Reset clears the per-entry valid bits, so unwritten history reads as zero and
// samples are taken right after reset.
// m_tready low holds the output register; the stages behind it fill, then s_tready drops.
module multichannel_biquad_iir (
  input  logic        clk,
  input  logic        rst,
  // APB configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // [23:0] sample_in
  // output stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // [23:0] sample_out
  output logic [4:0]  m_tuser    // [2:0] channel_index, [4:3] frame_tag
);
  import mbiq_pkg::*;

  // Coefficient registers
  logic signed [COEF_W-1:0] coef_ff0, coef_ff1, coef_ff2, coef_fb1, coef_fb2;
  logic                     cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      coef_ff0 <= FF0_RST;
      coef_ff1 <= FF1_RST;
      coef_ff2 <= FF2_RST;
      coef_fb1 <= FB1_RST;
      coef_fb2 <= FB2_RST;
    end else if (cfg_wr) begin
      case (paddr[4:2])
        REG_FF0: coef_ff0 <= pwdata;
        REG_FF1: coef_ff1 <= pwdata;
        REG_FF2: coef_ff2 <= pwdata;
        REG_FB1: coef_fb1 <= pwdata;
        REG_FB2: coef_fb2 <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      REG_FF0: prdata = coef_ff0;
      REG_FF1: prdata = coef_ff1;
      REG_FF2: prdata = coef_ff2;
      REG_FB1: prdata = coef_fb1;
      REG_FB2: prdata = coef_fb2;
      default: prdata = '0;
    endcase
  end

  // Pipeline state
  logic [CH_W-1:0]            ch_cnt, ch_cnt_next;
  logic                       s1_valid, s2_valid, out_valid;
  logic [CH_W-1:0]            s1_ch, s2_ch, out_ch;
  logic signed [SAMPLE_W-1:0] s1_x, s2_x, s2_x1;
  logic                       s1_fwd, s1_hist_ok;
  hist_t                      s1_fwd_data;
  logic signed [HIST_Y_W-1:0] s2_y1, out_y;
  logic signed [55:0]         s2_p0, s2_p1, s2_p2, s2_p3, s2_p4;
  logic signed [48:0]         s2_p5, s2_p6;
  logic [NUM_CHANNELS-1:0]    hist_valid;

  // Flow control
  logic out_free, s2_free, s1_free, s1_move, s2_move, hazard, accept;

  assign out_free = !out_valid || m_tready;
  assign s2_move  = s2_valid && out_free;
  assign s2_free  = !s2_valid || out_free;
  assign s1_move  = s1_valid && s2_free;
  assign s1_free  = !s1_valid || s2_free;

  // same channel still in flight and not yet written back
  assign hazard = (s1_valid && (s1_ch == ch_cnt)) ||
                  (s2_valid && (s2_ch == ch_cnt) && !s2_move);
  assign s_tready = s1_free && !hazard;
  assign accept   = s_tvalid && s_tready;

  // Channel rotation
  always_comb begin
    ch_cnt_next = ch_cnt;
    if (accept) begin
      if (ch_cnt == CH_W'(NUM_CHANNELS - 1)) begin
        ch_cnt_next = '0;
      end else begin
        ch_cnt_next = ch_cnt + 1'b1;
      end
    end
  end

  // History RAM
  hist_t             ram_rd, wr_word;
  logic [ADDR_W-1:0] rd_addr, wr_addr;
  logic              wr_en;
  logic signed [HIST_Y_W-1:0] y_new;

  assign rd_addr = ch_cnt[ADDR_W-1:0];
  assign wr_addr = s2_ch[ADDR_W-1:0];
  assign wr_en   = s2_move;

  always_comb begin
    wr_word.x1 = s2_x;
    wr_word.x2 = s2_x1;
    wr_word.y1 = y_new;
    wr_word.y2 = s2_y1;
  end

  mbiq_ram #(
    .WIDTH (HIST_W),
    .DEPTH (NUM_CHANNELS)
  ) u_hist_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_word),
    .rd_en   (accept),
    .rd_addr (rd_addr),
    .rd_data (ram_rd)
  );

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      ch_cnt     <= '0;
      s1_valid   <= 1'b0;
      s2_valid   <= 1'b0;
      out_valid  <= 1'b0;
      hist_valid <= '0;
    end else begin
      ch_cnt <= ch_cnt_next;
      if (accept) begin
        s1_valid <= 1'b1;
      end else if (s1_move) begin
        s1_valid <= 1'b0;
      end
      if (s1_move) begin
        s2_valid <= 1'b1;
      end else if (s2_move) begin
        s2_valid <= 1'b0;
      end
      if (s2_move) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
      if (wr_en) begin
        hist_valid[wr_addr] <= 1'b1;
      end
    end
  end

  // Stage 1 load: sample, channel, forwarding of a same-cycle write
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_x        <= s_tdata;
      s1_ch       <= ch_cnt;
      s1_fwd      <= wr_en && (wr_addr == rd_addr);
      s1_fwd_data <= wr_word;
      s1_hist_ok  <= hist_valid[rd_addr];
    end
  end

  // Stage 1: select history, form the seven partial products
  hist_t                      hist;
  logic signed [SAMPLE_W-1:0] yh1, yh2;
  logic signed [FRAC_W:0]     yl1, yl2;

  always_comb begin
    if (s1_fwd) begin
      hist = s1_fwd_data;
    end else if (s1_hist_ok) begin
      hist = ram_rd;
    end else begin
      hist = '0;
    end
    yh1 = hist.y1[HIST_Y_W-1:FRAC_W];
    yh2 = hist.y2[HIST_Y_W-1:FRAC_W];
    yl1 = {1'b0, hist.y1[FRAC_W-1:0]};
    yl2 = {1'b0, hist.y2[FRAC_W-1:0]};
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      s2_ch <= s1_ch;
      s2_x  <= s1_x;
      s2_x1 <= hist.x1;
      s2_y1 <= hist.y1;
      s2_p0 <= coef_ff0 * s1_x;
      s2_p1 <= coef_ff1 * hist.x1;
      s2_p2 <= coef_ff2 * hist.x2;
      s2_p3 <= coef_fb1 * yh1;
      s2_p4 <= coef_fb2 * yh2;
      s2_p5 <= coef_fb1 * yl1;
      s2_p6 <= coef_fb2 * yl2;
    end
  end

  // Stage 2: Q.46 sum, floor by 2^30, saturate to 40 bits
  logic signed [SUM_W-1:0] sum_hi, sum;
  logic signed [Q_W-1:0]   q;

  always_comb begin
    sum_hi = SUM_W'(s2_p0) + SUM_W'(s2_p1) + SUM_W'(s2_p2)
           - SUM_W'(s2_p3) - SUM_W'(s2_p4);
    sum    = (sum_hi <<< FRAC_W) - SUM_W'(s2_p5) - SUM_W'(s2_p6);
    q      = sum[SUM_W-1:QSHIFT];
    if (!q[Q_W-1] && (|q[Q_W-1:HIST_Y_W-1])) begin
      y_new = Y_MAX;
    end else if (q[Q_W-1] && !(&q[Q_W-1:HIST_Y_W-1])) begin
      y_new = Y_MIN;
    end else begin
      y_new = q[HIST_Y_W-1:0];
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (s2_move) begin
      out_y  <= y_new;
      out_ch <= s2_ch;
    end
  end

  // Integer part toward zero; always fits 24 bits after history saturation
  logic signed [HIST_Y_W-1:0] y_biased;

  assign y_biased = out_y + (out_y[HIST_Y_W-1] ? HIST_Y_W'({FRAC_W{1'b1}}) : '0);
  assign m_tvalid = out_valid;
  assign m_tdata  = y_biased[HIST_Y_W-1:FRAC_W];
  assign m_tuser  = {((out_ch == '0) ? TAG_FIRST : TAG_OTHER), out_ch};

`ifndef SYNTHESIS
  a_ch_range: assert property (@(posedge clk) disable iff (rst)
    ch_cnt < CH_W'(NUM_CHANNELS))
    else $error("channel counter out of range");

  a_no_raw: assert property (@(posedge clk) disable iff (rst)
    accept |-> !(s1_valid && (s1_ch == ch_cnt)))
    else $error("sample accepted behind an unfinished same-channel sample");

  a_fwd_capture: assert property (@(posedge clk) disable iff (rst)
    (accept && wr_en && (wr_addr == rd_addr)) |=> s1_fwd)
    else $error("same-entry write not forwarded");

  a_out_load: assert property (@(posedge clk) disable iff (rst)
    s2_move |=> (out_valid && (out_ch == $past(s2_ch))))
    else $error("result lost on the way to the output register");
`endif

endmodule

// File: rtl/mbiq_ram.sv
// Generic single-write, single-read RAM with registered read data.
module mbiq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // read returns the old word on a same-address write
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: tb/multichannel_biquad_iir_test.sv
`timescale 1ns / 100ps
// Self-checking testbench for the multichannel biquad filter: stream in, APB coefficients.
module multichannel_biquad_iir_test;
  import mbiq_pkg::*;

  localparam int WATCHDOG_LIMIT = 1000;
  localparam int DRAIN_CYCLES   = 8;
  localparam int RANDOM_ITEMS   = 410;
  localparam int DIR_ROWS       = 31;
  // index with no register behind it; writes there must be dropped
  localparam logic [2:0] REG_UNMAPPED = 3'd7;

  typedef enum logic [1:0] {ROW_COEF, ROW_CHECK, ROW_PREDICT} row_kind_t;

  typedef struct packed {
    row_kind_t         kind;
    logic [2:0]        reg_idx;
    logic [31:0]       value;   // coefficient, or sample in the low 24 bits
    logic signed [23:0] want;   // typed-in filter output for ROW_CHECK
  } dir_row_t;

  typedef struct packed {
    logic signed [23:0] sample;
    logic [2:0]         chan;
    logic [1:0]         tag;
  } filt_out_t;

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [4:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  logic        s_tvalid;
  logic        s_tready;
  logic [23:0] s_tdata;    // [23:0] sample_in
  logic        m_tvalid;
  logic        m_tready;
  logic [23:0] m_tdata;    // [23:0] sample_out
  logic [4:0]  m_tuser;    // [2:0] channel_index, [4:3] frame_tag

  // filter model state
  logic signed [31:0] coef [5];
  logic signed [23:0] x_hist [NUM_CHANNELS][2];
  logic signed [39:0] y_hist [NUM_CHANNELS][2];
  int                 chan_next;

  filt_out_t filtered_q [$];
  int        err_count;
  int        idle_cycles;
  bit        tx_burst;
  bit        rx_burst;

  dir_row_t dir_rows [DIR_ROWS] = '{
    // defaults after reset
    '{ROW_CHECK,   REG_FF0,      32'h0000_0000, 24'h000000},
    '{ROW_CHECK,   REG_FF0,      32'h0000_0000, 24'h000000},
    '{ROW_PREDICT, REG_FF0,      32'h007F_FFFF, 24'h000000},
    '{ROW_PREDICT, REG_FF0,      32'h0080_0000, 24'h000000},
    '{ROW_PREDICT, REG_FF0,      32'h0080_0000, 24'h000000},
    '{ROW_PREDICT, REG_FF0,      32'h007F_FFFF, 24'h000000},
    '{ROW_PREDICT, REG_FF0,      32'h0000_0001, 24'h000000},
    '{ROW_PREDICT, REG_FF0,      32'h00FF_FFFF, 24'h000000},
    // pass-through: ff0 = 1.0, rest zero; stray write to an empty slot
    '{ROW_COEF,    REG_FF0,      32'h4000_0000, 24'h000000},
    '{ROW_COEF,    REG_FF1,      32'h0000_0000, 24'h000000},
    '{ROW_COEF,    REG_FF2,      32'h0000_0000, 24'h000000},
    '{ROW_COEF,    REG_FB1,      32'h0000_0000, 24'h000000},
    '{ROW_COEF,    REG_FB2,      32'h0000_0000, 24'h000000},
    '{ROW_COEF,    REG_UNMAPPED, 32'h1234_5678, 24'h000000},
    '{ROW_CHECK,   REG_FF0,      32'h007F_FFFF, 24'h7FFFFF},
    '{ROW_CHECK,   REG_FF0,      32'h0080_0000, 24'h800000},
    '{ROW_CHECK,   REG_FF0,      32'h0000_0001, 24'h000001},
    '{ROW_CHECK,   REG_FF0,      32'h00FF_FFFF, 24'hFFFFFF},
    // gain -2.0: both ends of the range saturate
    '{ROW_COEF,    REG_FF0,      32'h8000_0000, 24'h000000},
    '{ROW_CHECK,   REG_FF0,      32'h0080_0000, 24'h7FFFFF},
    '{ROW_CHECK,   REG_FF0,      32'h007F_FFFF, 24'h800000},
    '{ROW_CHECK,   REG_FF0,      32'h0000_0003, 24'hFFFFFA},
    // extreme gains with runaway feedback
    '{ROW_COEF,    REG_FF0,      32'h7FFF_FFFF, 24'h000000},
    '{ROW_COEF,    REG_FB1,      32'h8000_0000, 24'h000000},
    '{ROW_COEF,    REG_FB2,      32'h7FFF_FFFF, 24'h000000},
    '{ROW_PREDICT, REG_FF0,      32'h007F_FFFF, 24'h000000},
    '{ROW_PREDICT, REG_FF0,      32'h0080_0000, 24'h000000},
    '{ROW_PREDICT, REG_FF0,      32'h0000_0000, 24'h000000},
    '{ROW_PREDICT, REG_FF0,      32'h0055_5555, 24'h000000},
    '{ROW_PREDICT, REG_FF0,      32'h00AA_AAAA, 24'h000000},
    '{ROW_PREDICT, REG_FF0,      32'h0000_0000, 24'h000000}
  };

  multichannel_biquad_iir dut (
    .clk      (clk),
    .rst      (rst),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // One biquad step for the channel in rotation; sum formed exactly in Q.46
  function automatic filt_out_t filter_sample(input logic signed [23:0] x);
    logic signed [79:0] c0, c1, c2, c3, c4;
    logic signed [79:0] xw0, xw1, xw2, yw1, yw2;
    logic signed [79:0] acc, yq, mag, s;
    logic signed [39:0] y;
    int                 ch;
    filt_out_t          r;
    ch  = (chan_next >= NUM_CHANNELS) ? 0 : chan_next;
    c0  = coef[REG_FF0];
    c1  = coef[REG_FF1];
    c2  = coef[REG_FF2];
    c3  = coef[REG_FB1];
    c4  = coef[REG_FB2];
    xw0 = x;
    xw1 = x_hist[ch][0];
    xw2 = x_hist[ch][1];
    yw1 = y_hist[ch][0];
    yw2 = y_hist[ch][1];
    acc = ((c0 * xw0 + c1 * xw1 + c2 * xw2) <<< 16) - c3 * yw1 - c4 * yw2;
    // arithmetic shift gives floor
    yq = acc >>> 30;
    if (yq > Y_MAX) y = Y_MAX;
    else if (yq < Y_MIN) y = Y_MIN;
    else y = yq[39:0];
    x_hist[ch][1] = x_hist[ch][0];
    x_hist[ch][0] = x;
    y_hist[ch][1] = y_hist[ch][0];
    y_hist[ch][0] = y;
    // integer part, toward zero
    mag = y;
    if (mag < 0) s = -((-mag) >>> 16);
    else s = mag >>> 16;
    if (s > 80'sd8388607) s = 80'sd8388607;
    if (s < -80'sd8388608) s = -80'sd8388608;
    r.sample  = s[23:0];
    r.chan    = 3'(ch);
    r.tag     = (ch == 0) ? TAG_FIRST : TAG_OTHER;
    chan_next = (ch + 1 >= NUM_CHANNELS) ? 0 : ch + 1;
    return r;
  endfunction

  function automatic int rand_between(input int lo, input int hi);
    return lo + int'($urandom_range(0, hi - lo));
  endfunction

  function automatic logic [23:0] random_sample();
    case ($urandom_range(0, 9))
      0: return 24'h7FFFFF;
      1: return 24'h800000;
      2, 3: return 24'(rand_between(-1000, 1000));
      default: return 24'($urandom);
    endcase
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch on %s at %0t: got %0d, expected %0d", what, $realtime, got, want);
    err_count++;
  endtask

  // Hold off the sender until every pending result is out
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (filtered_q.size() != 0);
  endtask

  // APB write: setup phase, access phase, then back to idle
  task automatic write_coef(input logic [2:0] idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (idx <= REG_FB2) coef[idx] = value;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // Offer one sample, predict on acceptance, then idle per the sender's draw
  task automatic send_sample(input logic [23:0] x, input bit has_want,
                             input logic signed [23:0] want);
    filt_out_t r;
    int        gap;
    s_tvalid <= 1'b1;
    s_tdata  <= x;
    do @(posedge clk); while (!s_tready);
    r = filter_sample(x);
    if (has_want) r.sample = want;
    filtered_q.push_back(r);
    gap = tx_burst ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      s_tdata  <= 24'($urandom);
      repeat (gap) @(posedge clk);
    end
  endtask

  // New coefficient set for a random phase
  task automatic write_random_coefs();
    logic [31:0] edge_vals [5];
    int          mode;
    edge_vals = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 32'h4000_0000, 32'hC000_0000};
    mode = $urandom_range(0, 3);
    for (int i = 0; i <= REG_FB2; i++) begin
      case (mode)
        0: begin
          case (i)
            REG_FF0: write_coef(3'(i), FF0_RST);
            REG_FF1: write_coef(3'(i), FF1_RST);
            REG_FF2: write_coef(3'(i), FF2_RST);
            REG_FB1: write_coef(3'(i), FB1_RST);
            default: write_coef(3'(i), FB2_RST);
          endcase
        end
        1: write_coef(3'(i), $urandom);
        2: begin
          // mostly well-behaved filters
          if (i == REG_FB1) write_coef(3'(i), 32'(rand_between(-(1 << 30), 0)));
          else if (i == REG_FB2) write_coef(3'(i), 32'(rand_between(0, 1 << 29)));
          else write_coef(3'(i), 32'(rand_between(-(1 << 28), 1 << 28)));
        end
        default: write_coef(3'(i), edge_vals[$urandom_range(0, 4)]);
      endcase
    end
  endtask

  // Result side: random back-pressure, compare against oldest prediction
  initial begin : result_sink
    int        stall;
    filt_out_t want;
    m_tready = 1'b0;
    while (rst !== 1'b0) @(posedge clk);
    forever begin
      stall = rx_burst ? 0 : $urandom_range(0, 19);
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      if (filtered_q.size() == 0) begin
        report_mismatch("unexpected transaction, sample_out", $signed(m_tdata), 0);
      end else begin
        want = filtered_q.pop_front();
        if (m_tdata !== want.sample)
          report_mismatch("sample_out", $signed(m_tdata), want.sample);
        if (m_tuser[2:0] !== want.chan)
          report_mismatch("channel_index", m_tuser[2:0], want.chan);
        if (m_tuser[4:3] !== want.tag)
          report_mismatch("frame_tag", m_tuser[4:3], want.tag);
      end
    end
  end

  // Count cycles with no transaction on any port
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
  end

  initial begin : watchdog
    while (idle_cycles < WATCHDOG_LIMIT) @(posedge clk);
    $display("timeout: no transaction for %0d cycles", WATCHDOG_LIMIT);
    $display("TB_ERROR");
    $finish;
  end

  // Main sequence: reset, directed table, random phases, drain
  initial begin : stimulus
    int sent;
    int phase_len;
    rst         = 1'b1;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = '0;
    pwdata      = '0;
    s_tvalid    = 1'b0;
    s_tdata     = '0;
    err_count   = 0;
    idle_cycles = 0;
    tx_burst    = 1'b0;
    rx_burst    = 1'b0;
    chan_next   = 0;
    coef[REG_FF0] = FF0_RST;
    coef[REG_FF1] = FF1_RST;
    coef[REG_FF2] = FF2_RST;
    coef[REG_FB1] = FB1_RST;
    coef[REG_FB2] = FB2_RST;
    for (int c = 0; c < NUM_CHANNELS; c++) begin
      x_hist[c] = '{24'sd0, 24'sd0};
      y_hist[c] = '{40'sd0, 40'sd0};
    end
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      case (dir_rows[i].kind)
        ROW_COEF: begin
          wait_drained();
          write_coef(dir_rows[i].reg_idx, dir_rows[i].value);
        end
        ROW_CHECK:   send_sample(dir_rows[i].value[23:0], 1'b1, dir_rows[i].want);
        default:     send_sample(dir_rows[i].value[23:0], 1'b0, '0);
      endcase
    end

    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      wait_drained();
      write_random_coefs();
      tx_burst  = ($urandom_range(0, 3) == 0);
      rx_burst  = ($urandom_range(0, 3) == 0);
      phase_len = $urandom_range(20, 60);
      repeat (phase_len) begin
        send_sample(random_sample(), 1'b0, '0);
        sent++;
      end
    end

    s_tvalid <= 1'b0;
    while (filtered_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_count == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule
